>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name before the first use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCMA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCMA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/scma_pkg.sv
// Package for the scanned-channel moving average: sizes, widths and the
// stage record passed between the front end and the accumulator. No dependencies.
package scma_pkg;

  localparam int RING_DEPTH        = 16;
  localparam int CHANNEL_COUNT     = 8;
  localparam int AVERAGED_CHANNELS = 3;

  localparam int SAMPLE_W   = 10;
  localparam int CH_W       = 3;
  localparam int AVG_W      = 10;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int RING_IDX_W = (AVERAGED_CHANNELS > 1) ? $clog2(AVERAGED_CHANNELS) : 1;
  localparam int RAM_DEPTH  = AVERAGED_CHANNELS * RING_DEPTH;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  // Floor of log2 of the ring depth.
  localparam int DEPTH_LOG2 = $clog2(RING_DEPTH + 1) - 1;
  localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int AVG_MAX    = (1 << AVG_W) - 1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CH_W-1:0]     chan_t;
  typedef logic [AVG_W-1:0]    avg_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // One item between the ring read and the sum update.
  typedef struct packed {
    chan_t                 channel;
    logic                  averaged;
    logic [RING_IDX_W-1:0] ring;
    sample_t               sample;
    logic                  old_vld;
  } stage_t;

endpackage

>>> rtl/scma_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-before-write when both ports hit the same address. No dependencies.
module scma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage and registered read; the read sees the old word on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/scma_front.sv
// Front end: channel pointer, per-ring write pointers, slot valid bits and
// ring memory addressing. Depends on scma_pkg.
module scma_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  scma_pkg::sample_t in_sample,
  output logic             in_stall,
  output logic             ram_we,
  output scma_pkg::addr_t  ram_addr,
  output scma_pkg::sample_t ram_wdata,
  output logic             s1_vld,
  output scma_pkg::stage_t s1,
  input  logic             s1_take
);
  import scma_pkg::*;

  chan_t                 chan_r, chan_nxt;
  logic [PTR_W-1:0]      wp_r [AVERAGED_CHANNELS];
  logic [PTR_W-1:0]      wp_cur, wp_nxt;
  logic [RAM_DEPTH-1:0]  slot_vld_r;
  logic                  s1_vld_r;
  stage_t                s1_r;
  logic                  accept;
  logic                  is_avg;
  logic [RING_IDX_W-1:0] ring;

  // The stage register frees up in the same cycle it hands its item on.
  assign in_stall = s1_vld_r && !s1_take;
  assign accept   = in_valid && !in_stall;

  assign is_avg = (chan_r < CH_W'(AVERAGED_CHANNELS));
  assign ring   = chan_r[RING_IDX_W-1:0];
  assign wp_cur = wp_r[ring];

  // Slot address of the oldest sample in this channel's ring.
  assign ram_addr  = ADDR_W'(int'(ring) * RING_DEPTH + int'(wp_cur));
  assign ram_we    = accept && is_avg;
  assign ram_wdata = in_sample;

  // Pointer wraps.
  always_comb begin
    wp_nxt   = (wp_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
    chan_nxt = (chan_r == CH_W'(CHANNEL_COUNT - 1)) ? '0 : chan_r + 1'b1;
  end

  // Control state: channel pointer, write pointers and slot valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= '0;
      slot_vld_r <= '0;
      s1_vld_r   <= 1'b0;
      for (int i = 0; i < AVERAGED_CHANNELS; i++) begin
        wp_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        chan_r   <= chan_nxt;
        s1_vld_r <= 1'b1;
        if (is_avg) begin
          wp_r[ring]           <= wp_nxt;
          slot_vld_r[ram_addr] <= 1'b1;
        end
      end else if (s1_take) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // Item record that waits for the ring read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.channel  <= chan_r;
      s1_r.averaged <= is_avg;
      s1_r.ring     <= ring;
      s1_r.sample   <= in_sample;
      s1_r.old_vld  <= is_avg && slot_vld_r[ram_addr];
    end
  end

  assign s1_vld = s1_vld_r;
  assign s1     = s1_r;

endmodule

>>> rtl/scma_accum.sv
// Accumulator: running sums per ring, average with saturation, and the
// output register. Depends on scma_pkg.
module scma_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_vld,
  input  scma_pkg::stage_t  s1,
  input  scma_pkg::sample_t ram_rdata,
  output logic              s1_take,
  output logic              out_valid,
  input  logic              out_stall,
  output scma_pkg::chan_t   out_sampled_channel,
  output logic              out_averaged,
  output scma_pkg::avg_t    out_average
);
  import scma_pkg::*;

  logic [SUM_W-1:0] sum_r [AVERAGED_CHANNELS];
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] shifted;
  sample_t          old_sample;
  avg_t             avg_nxt;
  logic             out_adv;
  logic             out_valid_r;
  chan_t            chan_out_r;
  logic             avg_flag_r;
  avg_t             avg_out_r;

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_take = s1_vld && out_adv;

  // A slot never written counts as zero.
  assign old_sample = s1.old_vld ? ram_rdata : '0;

  // Sum update and average; the previous item of the same channel has
  // always left this stage already, so the stored sum is current.
  always_comb begin
    sum_nxt = sum_r[s1.ring] - SUM_W'(old_sample) + SUM_W'(s1.sample);
    shifted = sum_nxt >> DEPTH_LOG2;
    if (!s1.averaged) begin
      avg_nxt = '0;
    end else if (shifted > SUM_W'(AVG_MAX)) begin
      avg_nxt = AVG_W'(AVG_MAX);
    end else begin
      avg_nxt = shifted[AVG_W-1:0];
    end
  end

  // Running sums and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < AVERAGED_CHANNELS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (out_adv) begin
        out_valid_r <= s1_vld;
      end
      if (s1_take && s1.averaged) begin
        sum_r[s1.ring] <= sum_nxt;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      chan_out_r <= s1.channel;
      avg_flag_r <= s1.averaged;
      avg_out_r  <= avg_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sampled_channel = chan_out_r;
  assign out_averaged        = avg_flag_r;
  assign out_average         = avg_out_r;

endmodule

>>> rtl/scanned_channel_moving_average.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_sample
// out_      output     out_valid/out_stall out_sampled_channel, out_averaged, out_average
//
// One item per cycle while out_stall is low; a taken item passes the stage register
// and then the output register, with the ring memory read and running sum update between.
// Synchronous active-low reset clears pointers, sums and slot valid bits at once.
// in_stall rises only when the stage and output registers are full and out_stall is high.
//
// Top level of the scanned-channel moving average. Depends on scma_pkg,
// scma_front, scma_ram and scma_accum.
module scanned_channel_moving_average (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  scma_pkg::sample_t in_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output scma_pkg::chan_t   out_sampled_channel,
  output logic              out_averaged,
  output scma_pkg::avg_t    out_average
);
  import scma_pkg::*;

  logic    ram_we;
  addr_t   ram_addr;
  sample_t ram_wdata;
  sample_t ram_rdata;
  logic    s1_vld;
  stage_t  s1;
  logic    s1_take;

  // Pointer and addressing front end.
  scma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_stall  (in_stall),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .s1_vld    (s1_vld),
    .s1        (s1),
    .s1_take   (s1_take)
  );

  // Ring storage: the new sample is written while the old one is read out.
  scma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_we),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Running sums and result register.
  scma_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s1_vld              (s1_vld),
    .s1                  (s1),
    .ram_rdata           (ram_rdata),
    .s1_take             (s1_take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sampled_channel (out_sampled_channel),
    .out_averaged        (out_averaged),
    .out_average         (out_average)
  );

endmodule

>>> rtl/scma_checker.sv
// Port-level checker for the scanned-channel moving average and its bind.
// Depends on scma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scma_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input scma_pkg::sample_t in_sample,
  input logic              out_valid,
  input logic              out_stall,
  input scma_pkg::chan_t   out_sampled_channel,
  input logic              out_averaged,
  input scma_pkg::avg_t    out_average
);
  import scma_pkg::*;

  chan_t exp_ch_r;
  logic  in_seen;

  // Tie off the input payload; only the result side is checked here.
  assign in_seen = in_valid && !in_stall && (in_sample == in_sample);

  // Channel that the next result must carry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_ch_r <= (exp_ch_r == CH_W'(CHANNEL_COUNT - 1)) ? '0 : exp_ch_r + 1'b1;
    end
  end

  `SCMA_ASSERT_SAME(a_chan_order, clk, rst_n, out_valid || in_seen, !out_valid || out_sampled_channel == exp_ch_r, "result channel out of round-robin order")
  `SCMA_ASSERT_SAME(a_avg_flag, clk, rst_n, out_valid, out_averaged == (out_sampled_channel < CH_W'(AVERAGED_CHANNELS)), "averaged flag does not match channel")
  `SCMA_ASSERT_SAME(a_zero_avg, clk, rst_n, out_valid && !out_averaged, out_average == '0, "non-averaged channel with nonzero average")
  `SCMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_average) && $stable(out_sampled_channel) && $stable(out_averaged), "stalled result changed")

endmodule

bind scanned_channel_moving_average scma_checker u_scma_checker (.*);
